// File: rtl/awbd_pkg.sv
// shared types and constants of the alpha-weighted box downsampler
`default_nettype none
package awbd_pkg;

	localparam int DIV_W     = 5;
	localparam int SIDE_W    = 13;
	localparam int COL_W     = 12;
	localparam int REG_IDX_W = 2;
	localparam int SIDE_LIMIT = 4096;

	localparam logic [REG_IDX_W-1:0] REG_DIVISOR = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT  = 2'd2;

	typedef struct packed {
		logic [7:0] pix_red;
		logic [7:0] pix_green;
		logic [7:0] pix_blue;
		logic [7:0] pix_alpha;
	} pix_t;

	typedef struct packed {
		logic [7:0] avg_red;
		logic [7:0] avg_green;
		logic [7:0] avg_blue;
		logic [7:0] avg_alpha;
		logic       end_of_row;
		logic       end_of_image;
	} avg_t;

endpackage
`default_nettype wire

// File: rtl/awbd_acc_mem.sv
// per-column accumulator memory, one write and one registered read port
`default_nettype none
module awbd_acc_mem #(
	parameter int DEPTH = 2048,
	parameter int W = 82
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [W-1:0]             wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [W-1:0]                  rd_data
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/awbd_div.sv
// restoring divider giving an 8-bit quotient, one bit per cycle
`default_nettype none
module awbd_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [7:0]            quot
);
	localparam int W = (NUM_W > DEN_W + 8) ? NUM_W : DEN_W + 8;

	logic [W-1:0] rem_q;
	logic [W-1:0] den_q;
	logic [2:0]   step_q;
	logic         busy_q;
	logic         done_q;
	logic [7:0]   quot_q;
	logic [W-1:0] trial;

	// quotient is known to stay below 256, so eight steps suffice
	assign trial = den_q << step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && step_q == 3'd0) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= W'(num);
			den_q  <= W'(den);
			step_q <= 3'd7;
			quot_q <= 8'd0;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				quot_q[step_q] <= 1'b1;
			end
			step_q <= step_q - 3'd1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// File: rtl/alpha_weighted_box_downsample_core.sv
// alpha-weighted box downsampler: control, accumulation, division and output register
// one word in flight: accept, memory read, read-modify-write of the column sums
// a word that closes no block returns to idle after the read-modify-write;
// pass-through (divisor 1) waits for the output register, others for dividers too
// reset clears counters and control; accumulator memory is not cleared, every
// entry is overwritten at the first word of its block, whose read value is ignored
`default_nettype none
module alpha_weighted_box_downsample_core #(
	parameter int MAX_OUT_COLUMNS = 2048,
	parameter int MAX_DIVISOR = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [awbd_pkg::REG_IDX_W-1:0]    wr_index,
	input  wire logic [awbd_pkg::SIDE_W-1:0]       wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire awbd_pkg::pix_t                    in_word,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output awbd_pkg::avg_t                         out_word
);
	import awbd_pkg::*;

	localparam int SQ    = MAX_DIVISOR * MAX_DIVISOR;
	localparam int CNT_W = $clog2(SQ + 1);
	localparam int AS_W  = 8 + $clog2(SQ);
	localparam int CS_W  = 16 + $clog2(SQ);
	localparam int MW    = 3 * CS_W + AS_W + CNT_W;
	localparam int OC_W  = $clog2(MAX_OUT_COLUMNS);
	localparam int DW    = $clog2(MAX_DIVISOR + 1);
	localparam int PW    = $clog2(MAX_DIVISOR);
	localparam int W_CAP = (2 * MAX_OUT_COLUMNS < SIDE_LIMIT) ? 2 * MAX_OUT_COLUMNS : SIDE_LIMIT;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ACC  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [DIV_W-1:0]  divisor_q;
	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;

	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] row_q;
	logic [PW-1:0]    cphase_q;
	logic [PW-1:0]    rphase_q;
	logic [OC_W-1:0]  ocol_q;
	logic [1:0]       state_q;

	logic [DW-1:0]     d_eff;
	logic [SIDE_W-1:0] w_eff;
	logic [SIDE_W-1:0] h_eff;
	logic              last_col;
	logic              last_row;
	logic              cp_end;
	logic              rp_end;
	logic              accept;

	pix_t            pix_s1;
	logic            first_s1;
	logic            emit_s1;
	logic            pass_s1;
	logic            last_col_s1;
	logic            last_row_s1;
	logic [OC_W-1:0] oc_s1;

	logic [MW-1:0]    rd_data;
	logic [MW-1:0]    wr_word;
	logic [CS_W-1:0]  rd_red, rd_green, rd_blue;
	logic [AS_W-1:0]  rd_alpha;
	logic [CNT_W-1:0] rd_cnt;
	logic [CS_W-1:0]  new_red, new_green, new_blue;
	logic [AS_W-1:0]  new_alpha;
	logic [CNT_W-1:0] new_cnt;
	logic [15:0]      prod_red, prod_green, prod_blue;

	logic       div_start;
	logic       as_zero_q;
	logic       done_r, done_g, done_b, done_a;
	logic [7:0] q_r, q_g, q_b, q_a;
	logic       out_free;
	logic       result_ready;
	logic       out_load;
	logic       out_valid_q;
	avg_t       out_word_q;

	// effective register values
	always_comb begin
		if (divisor_q == '0) begin
			d_eff = DW'(1);
		end else if (32'(divisor_q) > MAX_DIVISOR) begin
			d_eff = DW'(MAX_DIVISOR);
		end else begin
			d_eff = DW'(divisor_q);
		end
		if (width_q == '0) begin
			w_eff = SIDE_W'(1);
		end else if (32'(width_q) > W_CAP) begin
			w_eff = SIDE_W'(W_CAP);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = SIDE_W'(1);
		end else if (32'(height_q) > SIDE_LIMIT) begin
			h_eff = SIDE_W'(SIDE_LIMIT);
		end else begin
			h_eff = height_q;
		end
	end

	assign last_col = (SIDE_W'(col_q) + SIDE_W'(1)) >= w_eff;
	assign last_row = (SIDE_W'(row_q) + SIDE_W'(1)) >= h_eff;
	assign cp_end   = (DW'(cphase_q) + DW'(1)) >= d_eff;
	assign rp_end   = (DW'(rphase_q) + DW'(1)) >= d_eff;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIV_W'(4);
			width_q   <= SIDE_W'(256);
			height_q  <= SIDE_W'(512);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DIVISOR: divisor_q <= wr_data[DIV_W-1:0];
				REG_WIDTH:   width_q   <= wr_data;
				REG_HEIGHT:  height_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// position counters advance as each word is taken and restart on a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			cphase_q <= '0;
			rphase_q <= '0;
			ocol_q   <= '0;
		end else if (wr_en && (wr_index == REG_DIVISOR || wr_index == REG_WIDTH ||
				wr_index == REG_HEIGHT)) begin
			col_q    <= '0;
			row_q    <= '0;
			cphase_q <= '0;
			rphase_q <= '0;
			ocol_q   <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q    <= '0;
				cphase_q <= '0;
				ocol_q   <= '0;
				if (last_row) begin
					row_q    <= '0;
					rphase_q <= '0;
				end else begin
					row_q    <= row_q + COL_W'(1);
					rphase_q <= rp_end ? '0 : rphase_q + PW'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				if (cp_end) begin
					cphase_q <= '0;
					ocol_q   <= ocol_q + OC_W'(1);
				end else begin
					cphase_q <= cphase_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= in_word;
			first_s1    <= (cphase_q == '0) && (rphase_q == '0);
			emit_s1     <= (DW'(cphase_q) + DW'(1) == d_eff || last_col) &&
				(DW'(rphase_q) + DW'(1) == d_eff || last_row);
			pass_s1     <= (d_eff == DW'(1));
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
			oc_s1       <= ocol_q;
		end
	end

	// read-modify-write of the column sums
	assign {rd_red, rd_green, rd_blue, rd_alpha, rd_cnt} = rd_data;
	assign prod_red   = 16'(pix_s1.pix_red)   * 16'(pix_s1.pix_alpha);
	assign prod_green = 16'(pix_s1.pix_green) * 16'(pix_s1.pix_alpha);
	assign prod_blue  = 16'(pix_s1.pix_blue)  * 16'(pix_s1.pix_alpha);

	always_comb begin
		if (first_s1) begin
			new_red   = CS_W'(prod_red);
			new_green = CS_W'(prod_green);
			new_blue  = CS_W'(prod_blue);
			new_alpha = AS_W'(pix_s1.pix_alpha);
			new_cnt   = CNT_W'(1);
		end else begin
			new_red   = rd_red + CS_W'(prod_red);
			new_green = rd_green + CS_W'(prod_green);
			new_blue  = rd_blue + CS_W'(prod_blue);
			new_alpha = rd_alpha + AS_W'(pix_s1.pix_alpha);
			new_cnt   = rd_cnt + CNT_W'(1);
		end
	end

	assign wr_word = {new_red, new_green, new_blue, new_alpha, new_cnt};

	awbd_acc_mem #(
		.DEPTH (MAX_OUT_COLUMNS),
		.W     (MW)
	) u_mem (
		.clk     (clk),
		.wr_en   (state_q == S_ACC && !pass_s1),
		.wr_addr (oc_s1),
		.wr_data (wr_word),
		.rd_en   (accept),
		.rd_addr (ocol_q),
		.rd_data (rd_data)
	);

	assign div_start = (state_q == S_ACC) && !pass_s1 && emit_s1;

	always_ff @(posedge clk) begin
		if (div_start) begin
			as_zero_q <= (new_alpha == '0);
		end
	end

	awbd_div #(.NUM_W(CS_W), .DEN_W(AS_W)) u_div_r (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(new_red), .den(new_alpha), .done(done_r), .quot(q_r)
	);
	awbd_div #(.NUM_W(CS_W), .DEN_W(AS_W)) u_div_g (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(new_green), .den(new_alpha), .done(done_g), .quot(q_g)
	);
	awbd_div #(.NUM_W(CS_W), .DEN_W(AS_W)) u_div_b (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(new_blue), .den(new_alpha), .done(done_b), .quot(q_b)
	);
	awbd_div #(.NUM_W(AS_W), .DEN_W(CNT_W)) u_div_a (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(new_alpha), .den(new_cnt), .done(done_a), .quot(q_a)
	);

	assign out_free     = !out_valid_q || !out_stall;
	assign result_ready = pass_s1 || (done_r && done_g && done_b && done_a);
	assign out_load     = (state_q == S_DIV) && result_ready && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= (pass_s1 || emit_s1) ? S_DIV : S_IDLE;
				end
				S_DIV: if (out_load) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register frees the pipe while a word waits downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (pass_s1) begin
				out_word_q.avg_red   <= pix_s1.pix_red;
				out_word_q.avg_green <= pix_s1.pix_green;
				out_word_q.avg_blue  <= pix_s1.pix_blue;
				out_word_q.avg_alpha <= pix_s1.pix_alpha;
			end else begin
				out_word_q.avg_red   <= as_zero_q ? 8'd0 : q_r;
				out_word_q.avg_green <= as_zero_q ? 8'd0 : q_g;
				out_word_q.avg_blue  <= as_zero_q ? 8'd0 : q_b;
				out_word_q.avg_alpha <= q_a;
			end
			out_word_q.end_of_row   <= last_col_s1;
			out_word_q.end_of_image <= last_col_s1 && last_row_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && out_stall))
		else $error("output word overwritten while stalled");

	a_acc_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |=> (state_q == S_IDLE || state_q == S_DIV))
		else $error("bad step after accumulation");

	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !done_r && !done_a)
		else $error("divider reports done right after start");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("second word taken while one is in flight");
endmodule
`default_nettype wire
